// ----- rtl/core/gsa_pkg.sv -----
package gsa_pkg;

  // sizes
  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = 6;
  localparam int GEN_W      = 32;
  localparam int CNT_W      = 7;

  // request mode codes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_STALE = 2'd2
  } status_e;

  // internal operation after classification
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_CHECK,
    OP_NOP
  } op_e;

  // back end sequencer
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_QRD,
    SEQ_GRD
  } seq_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] slot_index;
    logic [GEN_W-1:0] handle_generation;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] granted_index;
    logic [GEN_W-1:0] granted_generation;
    logic             handle_valid;
  } rsp_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } link_t;

  // circular pointer advance over the slot range
  function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(SLOT_COUNT - 1)) begin
      r = '0;
    end else begin
      r = p + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/gsa_ram.sv -----
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/gsa_front.sv -----
module gsa_front
  import gsa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  input  req_t  req_i,
  output logic  full,
  output link_t cmd_o,
  input  logic  cmd_ready_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en;
  logic       rd_en;
  cmd_t       cls;

  // classify the request into an operation
  always_comb begin
    cls.idx = req_i.slot_index;
    cls.gen = req_i.handle_generation;
    unique case (req_i.mode)
      MODE_ALLOC: cls.op = OP_ALLOC;
      MODE_FREE:  cls.op = OP_FREE;
      MODE_CHECK: cls.op = OP_CHECK;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign full      = (cnt_q == 2'd2);
  assign wr_en     = push && !full;
  assign cmd_o.valid = (cnt_q != 2'd0);
  assign cmd_o.cmd   = mem_q[rd_ptr_q];
  assign rd_en     = cmd_o.valid && cmd_ready_i;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // command storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- rtl/core/gsa_back.sv -----
module gsa_back
  import gsa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  link_t cmd_i,
  output logic  cmd_ready_o,
  output logic  empty,
  input  logic  pop,
  output rsp_t  rsp_o
);

  seq_e                  state_q, state_d;
  cmd_t                  cur_q, cur_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [IDX_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      wr_cnt_q, wr_cnt_d;
  logic [SLOT_COUNT-1:0] gen_vld_q;

  logic             q_we;
  logic [IDX_W-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
  logic             g_we;
  logic [IDX_W-1:0] g_waddr, g_raddr;
  logic [GEN_W-1:0] g_wdata, g_rdata;

  logic             head_written;
  logic [IDX_W-1:0] slot;
  logic [GEN_W-1:0] gen_cur;
  logic             match;
  logic             in_range;

  rsp_t       res_mem_q [2];
  logic       res_wp_q, res_rp_q;
  logic [1:0] res_cnt_q;
  logic       res_push;
  logic       res_pop;
  rsp_t       res_d;

  // free index queue and generation table
  gsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  gsa_ram #(.WIDTH(GEN_W), .DEPTH(SLOT_COUNT)) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // entries never pushed still hold their own index
  assign head_written = ({1'b0, head_q} < wr_cnt_q);
  assign slot         = head_written ? q_rdata : head_q;
  // generations never written read as zero
  assign gen_cur      = gen_vld_q[cur_q.idx] ? g_rdata : '0;
  assign in_range     = ({1'b0, cmd_i.cmd.idx} < CNT_W'(SLOT_COUNT));
  assign match        = (gen_cur == cur_q.gen);

  // sequencer: next state, memory access and result
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    wr_cnt_d    = wr_cnt_q;
    cmd_ready_o = 1'b0;
    q_we        = 1'b0;
    q_waddr     = tail_q;
    q_wdata     = cur_q.idx;
    q_raddr     = head_q;
    g_we        = 1'b0;
    g_waddr     = cur_q.idx;
    g_wdata     = gen_cur + GEN_W'(1);
    g_raddr     = cmd_i.cmd.idx;
    res_push    = 1'b0;
    res_d       = '{status: ST_OK, granted_index: '0, granted_generation: '0,
                    handle_valid: 1'b0};
    unique case (state_q)
      SEQ_IDLE: begin
        if (cmd_i.valid && (res_cnt_q != 2'd2)) begin
          cmd_ready_o = 1'b1;
          cur_d       = cmd_i.cmd;
          unique case (cmd_i.cmd.op)
            OP_ALLOC: begin
              if (count_q == '0) begin
                res_push     = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                state_d = SEQ_QRD;
              end
            end
            OP_FREE, OP_CHECK: begin
              if (in_range) begin
                state_d = SEQ_GRD;
              end else begin
                res_push     = 1'b1;
                res_d.status = ST_STALE;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      SEQ_QRD: begin
        // pop the oldest free index, then fetch its generation
        cur_d.idx = slot;
        g_raddr   = slot;
        head_d    = next_ptr(head_q);
        count_d   = count_q - CNT_W'(1);
        state_d   = SEQ_GRD;
      end
      SEQ_GRD: begin
        res_push = 1'b1;
        state_d  = SEQ_IDLE;
        unique case (cur_q.op)
          OP_ALLOC: begin
            res_d.granted_index      = cur_q.idx;
            res_d.granted_generation = gen_cur;
          end
          OP_FREE: begin
            if (match) begin
              res_d.handle_valid = 1'b1;
              g_we               = 1'b1;
              if (count_q < CNT_W'(SLOT_COUNT)) begin
                q_we    = 1'b1;
                tail_d  = next_ptr(tail_q);
                count_d = count_q + CNT_W'(1);
                if (wr_cnt_q < CNT_W'(SLOT_COUNT)) begin
                  wr_cnt_d = wr_cnt_q + CNT_W'(1);
                end
              end
            end else begin
              res_d.status = ST_STALE;
            end
          end
          OP_CHECK: begin
            if (match) begin
              res_d.handle_valid = 1'b1;
            end else begin
              res_d.status = ST_STALE;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= CNT_W'(SLOT_COUNT);
      wr_cnt_q  <= '0;
      gen_vld_q <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      wr_cnt_q <= wr_cnt_d;
      if (g_we) begin
        gen_vld_q[g_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // result queue
  assign empty   = (res_cnt_q == 2'd0);
  assign res_pop = pop && !empty;
  assign rsp_o   = res_mem_q[res_rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wp_q  <= 1'b0;
      res_rp_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        res_wp_q <= !res_wp_q;
      end
      if (res_pop) begin
        res_rp_q <= !res_rp_q;
      end
      res_cnt_q <= res_cnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wp_q] <= res_d;
    end
  end

endmodule

// ----- rtl/core/generational_slot_allocator_top.sv -----
// Generational slot allocator: hands out (slot index, generation) handles.
// Request channel: req_i with push/full; a transfer happens on a rising edge
// with push high and full low. Mode 0 allocates the oldest free slot, mode 1
// frees a handle (its slot generation is raised and the index requeued while
// the free list has room), mode 2 checks a handle, mode 3 does nothing and
// returns an all-zero result. Result channel: rsp_o with empty/pop; the oldest
// result is shown while empty is low and leaves on a rising edge with pop high.
// Every request gives exactly one result, in request order.
// No-op, empty allocate and out-of-range handles are answered straight from the
// idle state; free and check go through the generation read first, and a
// successful allocate through the free index read and then the generation read
// (two dependent reads). One request is worked at a time, so the next request
// is not taken until the last one has given its result.
// Reset: all slots free in order 0 upward, all generations zero; usable as soon
// as reset is released, no clearing pass.
// A stalled receiver fills the two-entry result queue, then the two-entry
// request queue, after which full goes high.
module generational_slot_allocator_top
  import gsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output rsp_t rsp_o
);

  link_t cmd;
  logic  cmd_ready;

  // request intake and classification
  gsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .req_i       (req_i),
    .full        (full),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // allocation engine and result queue
  gsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- rtl/core/gsa_checker.sv -----
module gsa_checker
  import gsa_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic full,
  input logic empty,
  input logic pop,
  input rsp_t rsp_o
);

  // queue flags are always known out of reset
  a_flags_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({full, empty}))
    else $error("unknown queue flag");

  // a waiting result holds while not taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rsp_o)))
    else $error("result changed while stalled");

  // a matched handle always reports ok
  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.handle_valid) |-> (rsp_o.status == ST_OK))
    else $error("valid handle with error status");

  // empty queue result carries no grant
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.status == ST_EMPTY) |->
      (rsp_o.granted_index == '0 && rsp_o.granted_generation == '0 &&
       !rsp_o.handle_valid))
    else $error("no-slot result with nonzero fields");

  // stale handle result carries no grant
  a_stale_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.status == ST_STALE) |->
      (rsp_o.granted_index == '0 && rsp_o.granted_generation == '0 &&
       !rsp_o.handle_valid))
    else $error("stale result with nonzero fields");

endmodule

bind generational_slot_allocator_top gsa_checker u_gsa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .rsp_o  (rsp_o)
);

// ----- dv/tb_generational_slot_allocator_top.sv -----
module tb_generational_slot_allocator_top;
  import gsa_pkg::*;

  // mode three is unused by the block and must return an all-zero result
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 512;
  localparam int BIAS_STRETCH = 128;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } handle_t;

  // tracks free list and generations, holds the results still to come
  class slot_alloc_scoreboard;
    logic [IDX_W-1:0] free_ring[SLOT_COUNT];
    int               head;
    int               tail;
    int               free_count;
    logic [GEN_W-1:0] gen_tab[SLOT_COUNT];
    rsp_t             pending_rsp[$];
    handle_t          live[$];
    int               mismatches;
    int               n_requests;
    int               n_grants;
    int               n_empty;
    int               n_frees;
    int               n_stale;
    int               n_dropped;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        free_ring[i] = IDX_W'(i);
        gen_tab[i]   = '0;
      end
      head       = 0;
      tail       = 0;
      free_count = SLOT_COUNT;
      mismatches = 0;
      n_requests = 0;
      n_grants   = 0;
      n_empty    = 0;
      n_frees    = 0;
      n_stale    = 0;
      n_dropped  = 0;
    endfunction

    // work out the result of an accepted request and advance the state
    function void note_request(req_t r);
      rsp_t             e;
      logic [IDX_W-1:0] slot;
      handle_t          h;
      e = '0;
      n_requests++;
      case (r.mode)
        MODE_ALLOC: begin
          if (free_count == 0) begin
            e.status = ST_EMPTY;
            n_empty++;
          end else begin
            slot = free_ring[head];
            head = (head + 1) % SLOT_COUNT;
            free_count--;
            e.granted_index      = slot;
            e.granted_generation = gen_tab[slot];
            h.idx = slot;
            h.gen = gen_tab[slot];
            live.insert(live.size(), h);
            n_grants++;
          end
        end
        MODE_FREE: begin
          if (gen_tab[r.slot_index] == r.handle_generation) begin
            e.handle_valid = 1'b1;
            gen_tab[r.slot_index] = gen_tab[r.slot_index] + GEN_W'(1);
            n_frees++;
            // requeue only while there is room, otherwise it is lost
            if (free_count < SLOT_COUNT) begin
              free_ring[tail] = r.slot_index;
              tail = (tail + 1) % SLOT_COUNT;
              free_count++;
            end else begin
              n_dropped++;
            end
          end else begin
            e.status = ST_STALE;
            n_stale++;
          end
        end
        MODE_CHECK: begin
          if (gen_tab[r.slot_index] == r.handle_generation) begin
            e.handle_valid = 1'b1;
          end else begin
            e.status = ST_STALE;
            n_stale++;
          end
        end
        default: begin
          e = '0;
        end
      endcase
      pending_rsp.insert(pending_rsp.size(), e);
    endfunction

    // compare one result transfer against the oldest expectation
    function void check_result(rsp_t got);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: unexpected result %h", got);
        end
        return;
      end
      e = pending_rsp.pop_front();
      if (got.status !== e.status || got.granted_index !== e.granted_index ||
          got.granted_generation !== e.granted_generation ||
          got.handle_valid !== e.handle_valid) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: status %0d/%0d index %0d/%0d gen %h/%h valid %b/%b",
                   e.status, got.status, e.granted_index, got.granted_index,
                   e.granted_generation, got.granted_generation,
                   e.handle_valid, got.handle_valid);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  req_t req_i = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp_o;

  slot_alloc_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          quiet_cycles;

  generational_slot_allocator_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req_i),
    .empty (empty),
    .pop   (pop),
    .rsp_o (rsp_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: check on transfer, then decide the next pop
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_result(rsp_o);
    end
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // count cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL generational_slot_allocator_top");
    $finish;
  end

  function automatic req_t make_req(logic [1:0] mode, int idx, logic [GEN_W-1:0] gen);
    req_t r;
    r.mode              = mode;
    r.slot_index        = IDX_W'(idx);
    r.handle_generation = gen;
    return r;
  endfunction

  // request side: optional gap, then hold push until the transfer
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // allocates or handles that were handed out, some random noise
  task automatic random_request(input int unsigned alloc_pct, output req_t r,
                                output bit counted);
    int unsigned roll;
    int unsigned k;
    handle_t     h;
    r.mode              = MODE_ALLOC;
    r.slot_index        = IDX_W'($urandom);
    r.handle_generation = $urandom;
    counted             = 1'b1;
    roll                = $urandom_range(0, 99);
    if (roll < alloc_pct) begin
      // allocate, other fields carry random content
    end else if (roll < 92 && sb.live.size() > 0) begin
      k = $urandom_range(0, sb.live.size() - 1);
      h = sb.live[k];
      r.slot_index        = h.idx;
      r.handle_generation = h.gen;
      if ($urandom_range(0, 3) != 0) begin
        r.mode = MODE_FREE;
        sb.live.delete(k);
      end else begin
        r.mode = MODE_CHECK;
      end
      // stale generation now and then
      if ($urandom_range(0, 9) == 0) begin
        r.handle_generation = h.gen - GEN_W'($urandom_range(1, 2));
      end
    end else begin
      r.mode = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) begin
        r.handle_generation = sb.gen_tab[r.slot_index];
      end
      counted = (r.mode != MODE_NONE);
    end
  endtask

  // stimulus
  initial begin
    req_t        r;
    bit          counted;
    int          n_done;
    int unsigned alloc_pct;
    sb            = new();
    send_idle_pct = 34;
    recv_idle_pct = 66;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full-queue free, stale handles, duplicates, unused mode
    send_request(make_req(MODE_NONE, SLOT_COUNT - 1, '1));
    send_request(make_req(MODE_FREE, 5, '0));
    send_request(make_req(MODE_CHECK, 5, 32'd1));
    send_request(make_req(MODE_CHECK, 5, '0));
    send_request(make_req(MODE_FREE, 5, '0));
    send_request(make_req(MODE_ALLOC, 0, '0));
    send_request(make_req(MODE_ALLOC, SLOT_COUNT - 1, '1));
    send_request(make_req(MODE_ALLOC, 0, '0));
    send_request(make_req(MODE_FREE, 1, '0));
    send_request(make_req(MODE_FREE, 9, '0));
    send_request(make_req(MODE_CHECK, SLOT_COUNT - 1, '1));
    send_request(make_req(MODE_CHECK, 0, '0));
    send_request(make_req(MODE_CHECK, 9, 32'd1));
    send_request(make_req(MODE_FREE, 0, '1));
    send_request(make_req(MODE_NONE, 0, '0));

    // random phases with changing idle pattern, alloc bias swings to drain and refill
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      n_done = 0;
      while (n_done < RANDOM_PER_PHASE) begin
        alloc_pct = ((n_done / BIAS_STRETCH) % 2 == 0) ? 80 : 25;
        random_request(alloc_pct, r, counted);
        send_request(r);
        if (counted) begin
          n_done++;
        end
      end
    end
    push <= 1'b0;

    // drain
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.pending_rsp.size() != 0) begin
      sb.mismatches++;
    end
    $display("covered %0d requests: %0d grants, %0d allocates on an empty list,",
             sb.n_requests, sb.n_grants, sb.n_empty);
    $display("  %0d good frees (%0d with the list full), %0d stale handles, %0d mismatches",
             sb.n_frees, sb.n_dropped, sb.n_stale, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS generational_slot_allocator_top");
    end else begin
      $display("FAIL generational_slot_allocator_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/gsa_pkg.sv
rtl/core/gsa_ram.sv
rtl/core/gsa_front.sv
rtl/core/gsa_back.sv
rtl/core/generational_slot_allocator_top.sv
rtl/core/gsa_checker.sv
dv/tb_generational_slot_allocator_top.sv
